// ----- design/gnf_pkg.sv -----
// Shared constants, step codes and the corner gradient function for the fbm noise block.
package gnf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int IDX_W     = 8;
  localparam int COORD_W   = 32;
  localparam int FREQ_W    = 40;
  localparam int LAC_W     = 20;
  localparam int GAIN_W    = 17;
  localparam int OCTCFG_W  = 4;
  localparam int OUT_W     = 19;
  localparam int OUT_MAX   = 262143;
  localparam int OUT_NEG   = 262144;
  localparam int GRAD_W    = 19;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 21;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LACUN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd2;

  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Per-octave steps; all but the last issue a multiply, all but the first retire one.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_XLO  = 5'd0;
  localparam logic [STEP_W-1:0] ST_XHI  = 5'd1;
  localparam logic [STEP_W-1:0] ST_YLO  = 5'd2;
  localparam logic [STEP_W-1:0] ST_YHI  = 5'd3;
  localparam logic [STEP_W-1:0] ST_FX2  = 5'd4;
  localparam logic [STEP_W-1:0] ST_FXI  = 5'd5;
  localparam logic [STEP_W-1:0] ST_FX3  = 5'd6;
  localparam logic [STEP_W-1:0] ST_FY2  = 5'd7;
  localparam logic [STEP_W-1:0] ST_FXW  = 5'd8;
  localparam logic [STEP_W-1:0] ST_FYI  = 5'd9;
  localparam logic [STEP_W-1:0] ST_FY3  = 5'd10;
  localparam logic [STEP_W-1:0] ST_LX0  = 5'd11;
  localparam logic [STEP_W-1:0] ST_FYW  = 5'd12;
  localparam logic [STEP_W-1:0] ST_LX1  = 5'd13;
  localparam logic [STEP_W-1:0] ST_FQLO = 5'd14;
  localparam logic [STEP_W-1:0] ST_LXY  = 5'd15;
  localparam logic [STEP_W-1:0] ST_FQHI = 5'd16;
  localparam logic [STEP_W-1:0] ST_ACC  = 5'd17;
  localparam logic [STEP_W-1:0] ST_AMP  = 5'd18;
  localparam logic [STEP_W-1:0] ST_LAST = 5'd19;

  function automatic logic signed [GRAD_W-1:0] corner_grad(
    input logic [2:0] h,
    input logic signed [FRAC_BITS:0] x,
    input logic signed [FRAC_BITS:0] y
  );
    logic signed [GRAD_W-1:0] uu;
    logic signed [GRAD_W-1:0] vv;
    logic signed [GRAD_W-1:0] r;
    uu = h[2] ? GRAD_W'(y) : GRAD_W'(x);
    vv = h[2] ? GRAD_W'(x) : GRAD_W'(y);
    r  = h[0] ? -uu : uu;
    r  = h[1] ? (r - (vv <<< 1)) : (r + (vv <<< 1));
    return r;
  endfunction

endpackage

// ----- design/gnf_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned.
module gnf_div
  import gnf_pkg::*;
#(
  parameter int DV_W  = 39,
  parameter int TOT_W = 21
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DV_W-1:0]  dividend_i,
  input  logic [TOT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DV_W-1:0]  quot_o
);

  localparam int CNT_W = $clog2(DV_W + 1);

  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DV_W-1:0]  dvd_q;
  logic [TOT_W-1:0] rem_q;
  logic [TOT_W-1:0] dsr_q;
  logic [TOT_W:0]   trial;
  logic [TOT_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, dvd_q[DV_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(DV_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
      dvd_q <= {dvd_q[DV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// ----- design/gradient_noise_fbm_2d_top.sv -----
// Fractal 2D gradient noise: permutation memory, per-octave sequencer and normalization.
//
// Requests enter on start while busy is low. operation_i = 1 stores perm_value_i
// into permutation entry perm_index_i in that cycle and yields nothing; busy stays low.
// operation_i = 0 samples (coord_x_i, coord_y_i) and later yields one noise_value_o,
// marked by a one-cycle noise_valid_o strobe in the same cycle busy drops.
// Every permutation entry that an evaluation touches must have been written first.
// Configuration goes through cfg_valid_i/cfg_index_i/cfg_data_i; cfg_ready_o is always
// high, and writes belong in idle time.
// An evaluation holds busy through one octave schedule per octave and then the division
// (SUM_W+16 = 39 quotient bits at MAX_OCTAVES = 8, then the divider's done strobe). The
// next request can be accepted at the edge that ends the strobe cycle.
// Each octave is a 20-step schedule around one shared 33x21 multiplier, with the six
// hash reads on the single read port of the permutation memory overlapped; the final normalization
// runs on a bit-serial divider. Items are processed one at a time.
// Reset returns the configuration registers to their defaults and the block to idle;
// the permutation memory is not cleared. The receiver cannot stall results.
module gradient_noise_fbm_2d_top
  import gnf_pkg::*;
#(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation_i,
  input  logic signed [COORD_W-1:0]   coord_x_i,
  input  logic signed [COORD_W-1:0]   coord_y_i,
  input  logic [IDX_W-1:0]            perm_index_i,
  input  logic [IDX_W-1:0]            perm_value_i,
  output logic signed [OUT_W-1:0]     noise_value_o,
  output logic                        noise_valid_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DAT_W-1:0]        cfg_data_i
);

  localparam int OC_W  = $clog2(MAX_OCTAVES + 1);
  localparam int SUM_W = 19 + $clog2(MAX_OCTAVES + 1);
  localparam int TOT_W = 17 + $clog2(MAX_OCTAVES + 1);
  localparam int DV_W  = SUM_W + FRAC_BITS;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_OCT  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]        ph_q;
  logic [STEP_W-1:0] step_q;
  logic [OC_W-1:0]   oct_left_q;
  logic [OC_W-1:0]   oct_init;
  logic [OCTCFG_W-1:0] octave_count_q;
  logic [LAC_W-1:0]  lac_q;
  logic [GAIN_W-1:0] gain_cfg_q;
  logic [GAIN_W-1:0] gain_sat;
  logic              neg_q;
  logic              valid_q;
  logic signed [OUT_W-1:0] res_q;
  logic signed [OUT_W-1:0] res_d;

  logic accept, eval_start, perm_wr;

  // datapath
  logic signed [COORD_W-1:0] ux_q, uy_q;
  logic [FREQ_W-1:0]    freq_q;
  logic [GAIN_W-1:0]    amp_q, gain_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [TOT_W-1:0]     total_q;
  logic [23:0]          sacc_q, ftmp_q;
  logic [23:0]          s_full;
  logic [IDX_W-1:0]     cx_q, cy_q, ha_q, hb_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q, t2x_q, t3x_q, t2y_q, t3y_q;
  logic [19:0]          inx_q, iny_q;
  logic [FRAC_BITS:0]   u_q, v_q;
  logic signed [GRAD_W-1:0] g00_q, g01_q, g10_q, g11_q;
  logic signed [GRAD_W-1:0] lx0_q, lx1_q, lerp_l, n_q;
  logic [19:0]          cx15, cy15;
  logic [44:0]          fsum;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_q;

  // permutation memory
  logic [IDX_W-1:0] perm_mem [2**IDX_W];
  logic [IDX_W-1:0] perm_rd_q;
  logic [IDX_W-1:0] raddr;

  logic             div_start, div_done;
  logic [SUM_W-1:0] sum_mag;
  logic [DV_W-1:0]  quot;

  assign accept      = start && !busy;
  assign eval_start  = accept && (operation_i == OP_EVAL);
  assign perm_wr     = accept && (operation_i == OP_WRITE);
  assign busy        = (ph_q != PH_IDLE);
  assign cfg_ready_o = 1'b1;
  assign div_start   = (ph_q == PH_OCT) && (step_q == ST_LAST) && (oct_left_q == OC_W'(1));

  always_comb begin
    if (octave_count_q == '0) begin
      oct_init = OC_W'(1);
    end else if (int'(octave_count_q) > MAX_OCTAVES) begin
      oct_init = OC_W'(MAX_OCTAVES);
    end else begin
      oct_init = OC_W'(octave_count_q);
    end
    gain_sat = (int'(gain_cfg_q) > ONE) ? GAIN_W'(ONE) : gain_cfg_q;
  end

  // control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q           <= PH_IDLE;
      step_q         <= ST_XLO;
      oct_left_q     <= '0;
      valid_q        <= 1'b0;
      octave_count_q <= OCTCFG_W'(1);
      lac_q          <= LAC_W'(131072);
      gain_cfg_q     <= GAIN_W'(32768);
    end else begin
      valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_OCTAVES: octave_count_q <= cfg_data_i[OCTCFG_W-1:0];
          CFG_LACUN:   lac_q          <= cfg_data_i[LAC_W-1:0];
          CFG_GAIN:    gain_cfg_q     <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      case (ph_q)
        PH_IDLE: begin
          if (eval_start) begin
            ph_q       <= PH_OCT;
            step_q     <= ST_XLO;
            oct_left_q <= oct_init;
          end
        end
        PH_OCT: begin
          if (step_q == ST_LAST) begin
            step_q <= ST_XLO;
            if (div_start) begin
              ph_q <= PH_DIV;
            end else begin
              oct_left_q <= oct_left_q - 1'b1;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        PH_DIV: begin
          if (div_done) begin
            ph_q    <= PH_IDLE;
            valid_q <= 1'b1;
          end
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  // memory: write on write requests, read address follows the hash schedule
  always_ff @(posedge clk_i) begin
    if (perm_wr) begin
      perm_mem[perm_index_i] <= perm_value_i;
    end
  end

  always_comb begin
    case (step_q)
      ST_YHI:  raddr = cx_q;
      ST_FX2:  raddr = cx_q + 1'b1;
      ST_FXI:  raddr = ha_q + cy_q;
      ST_FX3:  raddr = ha_q + cy_q + 1'b1;
      ST_FY2:  raddr = hb_q + cy_q;
      ST_FXW:  raddr = hb_q + cy_q + 1'b1;
      default: raddr = cx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    perm_rd_q <= perm_mem[raddr];
  end

  // shared multiplier operands
  assign cx15 = 20'(15 * ONE) - ({2'b0, fx_q, 2'b0} + {3'b0, fx_q, 1'b0});
  assign cy15 = 20'(15 * ONE) - ({2'b0, fy_q, 2'b0} + {3'b0, fy_q, 1'b0});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      ST_XLO:  begin mul_a = MUL_A_W'(ux_q); mul_b = {1'b0, freq_q[19:0]}; end
      ST_XHI:  begin mul_a = MUL_A_W'(ux_q); mul_b = {1'b0, freq_q[39:20]}; end
      ST_YLO:  begin mul_a = MUL_A_W'(uy_q); mul_b = {1'b0, freq_q[19:0]}; end
      ST_YHI:  begin mul_a = MUL_A_W'(uy_q); mul_b = {1'b0, freq_q[39:20]}; end
      ST_FX2:  begin mul_a = {17'b0, fx_q};  mul_b = {5'b0, fx_q}; end
      ST_FXI:  begin mul_a = {17'b0, fx_q};  mul_b = {1'b0, cx15}; end
      ST_FX3:  begin mul_a = {17'b0, t2x_q}; mul_b = {5'b0, fx_q}; end
      ST_FY2:  begin mul_a = {17'b0, fy_q};  mul_b = {5'b0, fy_q}; end
      ST_FXW:  begin mul_a = {17'b0, t3x_q}; mul_b = {1'b0, inx_q}; end
      ST_FYI:  begin mul_a = {17'b0, fy_q};  mul_b = {1'b0, cy15}; end
      ST_FY3:  begin mul_a = {17'b0, t2y_q}; mul_b = {5'b0, fy_q}; end
      ST_LX0:  begin
        mul_a = MUL_A_W'($signed({g10_q[GRAD_W-1], g10_q} - {g00_q[GRAD_W-1], g00_q}));
        mul_b = {4'b0, u_q};
      end
      ST_FYW:  begin mul_a = {17'b0, t3y_q}; mul_b = {1'b0, iny_q}; end
      ST_LX1:  begin
        mul_a = MUL_A_W'($signed({g11_q[GRAD_W-1], g11_q} - {g01_q[GRAD_W-1], g01_q}));
        mul_b = {4'b0, u_q};
      end
      ST_FQLO: begin mul_a = {13'b0, freq_q[19:0]};  mul_b = {1'b0, lac_q}; end
      ST_LXY:  begin
        mul_a = MUL_A_W'($signed({lx1_q[GRAD_W-1], lx1_q} - {lx0_q[GRAD_W-1], lx0_q}));
        mul_b = {4'b0, v_q};
      end
      ST_FQHI: begin mul_a = {13'b0, freq_q[39:20]}; mul_b = {1'b0, lac_q}; end
      ST_ACC:  begin mul_a = MUL_A_W'(n_q);   mul_b = {4'b0, amp_q}; end
      ST_AMP:  begin mul_a = {16'b0, amp_q};  mul_b = {4'b0, gain_q}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  assign s_full = sacc_q + {prod_q[19:0], 4'b0};
  assign lerp_l = lx0_q + GRAD_W'(prod_q[FRAC_BITS+GRAD_W-1:FRAC_BITS]);
  assign fsum   = {1'b0, prod_q[39:0], 4'b0} + {21'b0, ftmp_q};

  // start-of-evaluation setup, writeback of the product issued in the previous step, plus hash captures
  always_ff @(posedge clk_i) begin
    if (eval_start) begin
      ux_q    <= coord_x_i;
      uy_q    <= coord_y_i;
      freq_q  <= FREQ_W'(ONE);
      amp_q   <= GAIN_W'(ONE);
      gain_q  <= gain_sat;
      sum_q   <= '0;
      total_q <= '0;
    end else if (ph_q == PH_OCT) begin
      case (step_q)
        ST_XHI:  sacc_q <= prod_q[39:16];
        ST_YLO:  begin cx_q <= s_full[23:16]; fx_q <= s_full[15:0]; end
        ST_YHI:  sacc_q <= prod_q[39:16];
        ST_FX2:  begin cy_q <= s_full[23:16]; fy_q <= s_full[15:0]; ha_q <= perm_rd_q; end
        ST_FXI:  begin t2x_q <= prod_q[31:16]; hb_q <= perm_rd_q; end
        ST_FX3:  begin
          inx_q <= 20'(10 * ONE) - prod_q[35:16];
          g00_q <= corner_grad(perm_rd_q[2:0], {1'b0, fx_q}, {1'b0, fy_q});
        end
        ST_FY2:  begin
          t3x_q <= prod_q[31:16];
          g01_q <= corner_grad(perm_rd_q[2:0], {1'b0, fx_q}, {1'b1, fy_q});
        end
        ST_FXW:  begin
          t2y_q <= prod_q[31:16];
          g10_q <= corner_grad(perm_rd_q[2:0], {1'b1, fx_q}, {1'b0, fy_q});
        end
        ST_FYI:  begin
          u_q   <= prod_q[32:16];
          g11_q <= corner_grad(perm_rd_q[2:0], {1'b1, fx_q}, {1'b1, fy_q});
        end
        ST_FY3:  iny_q  <= 20'(10 * ONE) - prod_q[35:16];
        ST_LX0:  t3y_q  <= prod_q[31:16];
        ST_FYW:  lx0_q  <= g00_q + GRAD_W'(prod_q[FRAC_BITS+GRAD_W-1:FRAC_BITS]);
        ST_LX1:  v_q    <= prod_q[32:16];
        ST_FQLO: lx1_q  <= g01_q + GRAD_W'(prod_q[FRAC_BITS+GRAD_W-1:FRAC_BITS]);
        ST_LXY:  ftmp_q <= prod_q[39:16];
        ST_FQHI: n_q    <= (lerp_l >>> 1) + GRAD_W'(ONE / 2);
        ST_ACC:  freq_q <= (|fsum[44:40]) ? '1 : fsum[39:0];
        ST_AMP:  begin
          sum_q   <= sum_q + SUM_W'(prod_q[FRAC_BITS+SUM_W-1:FRAC_BITS]);
          total_q <= total_q + TOT_W'(amp_q);
        end
        ST_LAST: amp_q <= prod_q[32:16];
        default: ;
      endcase
    end
  end

  // normalization
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      neg_q <= sum_q[SUM_W-1];
    end
  end

  gnf_div #(
    .DV_W  (DV_W),
    .TOT_W (TOT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_mag, {FRAC_BITS{1'b0}}}),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    if (neg_q) begin
      res_d = (quot > DV_W'(OUT_NEG)) ? OUT_W'(-OUT_NEG) : OUT_W'(0) - quot[OUT_W-1:0];
    end else begin
      res_d = (quot > DV_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : quot[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      res_q <= res_d;
    end
  end

  assign noise_value_o = res_q;
  assign noise_valid_o = valid_q;

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_start |=> busy)
    else $error("evaluation did not start");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    perm_wr |=> !busy)
    else $error("table write made block busy");

  a_done_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (ph_q == PH_DIV))
    else $error("divider finished outside division phase");

endmodule
